>>> rtl/fbpa_pkg.sv
package fbpa_pkg;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam int DEF_ADDR_BITS  = 32;

    // field widths of the stream payloads
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int USED_W      = 9;
    localparam int BYTES_W     = 21;
    localparam int REQ_W       = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;

    // configuration registers
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int BSIZE_W     = 13;
    localparam int BCOUNT_W    = 9;

    // rounded block size reaches 8192, one bit past the request field
    localparam int ELEM_W      = 14;
    localparam int PROD_W      = USED_W + ELEM_W;

    localparam logic [USED_W-1:0]   BLOCKS_SAT = {USED_W{1'b1}};
    localparam logic [BYTES_W-1:0]  BYTES_SAT  = {BYTES_W{1'b1}};

    localparam logic [ELEM_W-1:0]   ELEM_RESET   = ELEM_W'(8);
    localparam logic [BSIZE_W-1:0]  BSIZE_RESET  = BSIZE_W'(8);
    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = BCOUNT_W'(256);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REBUILD = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NULL_FREE = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_BLOCK_BYTES = 2'd1,
        CFG_BLOCK_COUNT = 2'd2
    } cfg_idx_t;

    // at least 8, then up to a multiple of 8
    function automatic logic [ELEM_W-1:0] round_size(input logic [BSIZE_W-1:0] req);
        logic [ELEM_W-1:0] s;
        s = ELEM_W'(req);
        if (s < ELEM_RESET) begin
            s = ELEM_RESET;
        end
        s = s + ELEM_W'(7);
        return {s[ELEM_W-1:3], 3'b000};
    endfunction

endpackage

>>> rtl/fixed_block_pool_allocator_core.sv
// result path: free, empty alloc and ignored requests go from idle through finish into the output register,
//   a good alloc also passes the pop state (stack ram read), a rebuild first fills the clamped block_count entries
// request flow: a new request is taken only in idle, after the last result is loaded; the single stack ram and its
//   registered read add the pop state to a good alloc, and a result still waiting on m_tready holds the next one back
// reset: synchronous active-low; list empty, counters zero, registers at their defaults,
//   stack ram contents undefined and not cleared
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] free_address
    input  logic [REQ_W-1:0]       s_tuser,   // [1:0] req_type

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] block_address, [33:32] status,
                                              // [42:34] blocks_in_use, [63:43] bytes_in_use

    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int TOP_W   = $clog2(MAX_BLOCKS + 1);
    localparam int STORE_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int CNT_W   = (TOP_W > BCOUNT_W) ? TOP_W : BCOUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FILL,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [TOP_W-1:0]      top_reg;
    logic [USED_W-1:0]     used_reg;
    logic [ELEM_W-1:0]     elem_reg;
    logic [ADDR_W-1:0]     pool_base_reg;
    logic [BSIZE_W-1:0]    block_bytes_reg;
    logic [BCOUNT_W-1:0]   block_count_reg;
    logic [TOP_W-1:0]      fill_idx_reg;
    logic [TOP_W-1:0]      fill_n_reg;
    logic [STORE_W-1:0]    fill_addr_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    status_t               res_status_reg;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                  accept;
    logic                  out_free;
    logic                  is_empty;
    logic                  is_full;
    logic [TOP_W-1:0]      top_dec;
    logic [CNT_W-1:0]      cnt_ext;
    logic [TOP_W-1:0]      build_n;
    logic                  fill_last;
    logic [PROD_W-1:0]     prod;
    logic [BYTES_W-1:0]    bytes_sat;
    logic [ADDR_W-1:0]     free_addr;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [STORE_W-1:0]    ram_wr_data;
    logic                  ram_rd_en;
    logic [STORE_W-1:0]    ram_rd_data;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign free_addr = s_tdata[ADDR_W-1:0];

    assign is_empty  = (top_reg == '0);
    assign is_full   = (top_reg >= TOP_W'(MAX_BLOCKS));
    assign top_dec   = top_reg - TOP_W'(1);

    // block count clamped to the stack depth
    assign cnt_ext   = CNT_W'(block_count_reg);
    assign build_n   = (cnt_ext > CNT_W'(MAX_BLOCKS)) ? TOP_W'(MAX_BLOCKS) : TOP_W'(cnt_ext);
    assign fill_last = (fill_idx_reg == fill_n_reg - TOP_W'(1));

    // bytes in use is blocks in use times the latched size, saturated at the field maximum
    assign prod      = PROD_W'(used_reg) * PROD_W'(elem_reg);
    assign bytes_sat = (prod > PROD_W'(BYTES_SAT)) ? BYTES_SAT : prod[BYTES_W-1:0];

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = top_reg[IDX_W-1:0];
        ram_wr_data = free_addr[STORE_W-1:0];
        if (state_reg == ST_FILL) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_idx_reg[IDX_W-1:0];
            ram_wr_data = fill_addr_reg;
        end else if (accept && (s_tuser == REQ_FREE) && (free_addr != '0) && !is_full) begin
            ram_wr_en   = 1'b1;
        end
    end

    assign ram_rd_en = accept && (s_tuser == REQ_ALLOC) && !is_empty;

    fbpa_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (top_dec[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            top_reg         <= '0;
            used_reg        <= '0;
            elem_reg        <= ELEM_RESET;
            pool_base_reg   <= '0;
            block_bytes_reg <= BSIZE_RESET;
            block_count_reg <= BCOUNT_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_POOL_BASE:   pool_base_reg   <= cfg_wr_data[ADDR_W-1:0];
                    CFG_BLOCK_BYTES: block_bytes_reg <= cfg_wr_data[BSIZE_W-1:0];
                    CFG_BLOCK_COUNT: block_count_reg <= cfg_wr_data[BCOUNT_W-1:0];
                    default: ;
                endcase
            end

            // finish reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_addr_reg <= '0;
                        case (s_tuser)
                            REQ_ALLOC: begin
                                if (is_empty) begin
                                    res_status_reg <= STAT_EMPTY;
                                    state_reg      <= ST_FINISH;
                                end else begin
                                    res_status_reg <= STAT_OK;
                                    top_reg        <= top_dec;
                                    state_reg      <= ST_POP;
                                    if (used_reg != BLOCKS_SAT) begin
                                        used_reg <= used_reg + USED_W'(1);
                                    end
                                end
                            end
                            REQ_FREE: begin
                                state_reg <= ST_FINISH;
                                if (free_addr == '0) begin
                                    res_status_reg <= STAT_NULL_FREE;
                                end else if (is_full) begin
                                    res_status_reg <= STAT_FULL;
                                end else begin
                                    res_status_reg <= STAT_OK;
                                    top_reg        <= top_reg + TOP_W'(1);
                                    if (used_reg != '0) begin
                                        used_reg <= used_reg - USED_W'(1);
                                    end
                                end
                            end
                            REQ_REBUILD: begin
                                res_status_reg <= STAT_OK;
                                elem_reg       <= round_size(block_bytes_reg);
                                used_reg       <= '0;
                                top_reg        <= build_n;
                                fill_n_reg     <= build_n;
                                fill_idx_reg   <= '0;
                                fill_addr_reg  <= pool_base_reg[STORE_W-1:0];
                                state_reg      <= (build_n != '0) ? ST_FILL : ST_FINISH;
                            end
                            default: begin
                                res_status_reg <= STAT_OK;
                                state_reg      <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_POP: begin
                    res_addr_reg <= ADDR_W'(ram_rd_data);
                    state_reg    <= ST_FINISH;
                end
                ST_FILL: begin
                    fill_idx_reg  <= fill_idx_reg + TOP_W'(1);
                    fill_addr_reg <= fill_addr_reg + STORE_W'(elem_reg);
                    if (fill_last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {bytes_sat, used_reg, res_status_reg, res_addr_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/fbpa_ram.sv
module fbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/fbpa_checker.sv
module fbpa_checker
    import fbpa_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [ADDR_W-1:0]   res_addr;
    logic [STATUS_W-1:0] res_status;
    logic [USED_W-1:0]   res_used;
    logic [BYTES_W-1:0]  res_bytes;

    assign res_addr   = m_tdata[ADDR_W-1:0];
    assign res_status = m_tdata[ADDR_W +: STATUS_W];
    assign res_used   = m_tdata[ADDR_W + STATUS_W +: USED_W];
    assign res_bytes  = m_tdata[ADDR_W + STATUS_W + USED_W +: BYTES_W];

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a failing status hands out no address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_status != STAT_OK) |-> (res_addr == '0))
        else $error("address given with a failing status");

    // no bytes in use without blocks in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_used == '0) |-> (res_bytes == '0))
        else $error("bytes in use without blocks in use");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/fbpa_checker.sv
`timescale 1ns / 100ps
module fbpa_scoreboard
    import fbpa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] free_address
    input  logic [REQ_W-1:0]       s_tuser,   // [1:0] req_type

    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] block_address, [33:32] status,
                                              // [42:34] blocks_in_use, [63:43] bytes_in_use

    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,

    output int                     errors,
    output int                     pending,
    output int                     checked
);

    localparam int POOL_DEPTH = DEF_MAX_BLOCKS;
    localparam int REPORT_MAX = 100;

    typedef struct packed {
        logic [BYTES_W-1:0]  bytes;
        logic [USED_W-1:0]   used;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } pool_reply_t;

    // mirror of the pool
    logic [ADDR_W-1:0]   stack_mirror [POOL_DEPTH];
    logic [8:0]          free_top;
    logic [USED_W-1:0]   used_blocks;
    logic [BYTES_W-1:0]  used_bytes;
    logic [ELEM_W-1:0]   blk_size;

    logic [ADDR_W-1:0]   cfg_base;
    logic [BSIZE_W-1:0]  cfg_bytes;
    logic [BCOUNT_W-1:0] cfg_count;

    pool_reply_t replies_due[$];

    function automatic logic [ELEM_W-1:0] rounded_size(input logic [BSIZE_W-1:0] req);
        logic [ELEM_W-1:0] s;
        s = (req < BSIZE_W'(8)) ? ELEM_W'(8) : ELEM_W'(req);
        return (s + ELEM_W'(7)) & ~ELEM_W'(7);
    endfunction

    function automatic void refresh_bytes();
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(used_blocks) * PROD_W'(blk_size);
        used_bytes = (prod > PROD_W'(BYTES_SAT)) ? BYTES_SAT : prod[BYTES_W-1:0];
    endfunction

    function automatic pool_reply_t pool_step(input logic [REQ_W-1:0] kind,
                                              input logic [ADDR_W-1:0] addr_in);
        pool_reply_t r;
        logic [BCOUNT_W-1:0] n;
        int i;
        r.addr   = '0;
        r.status = STAT_OK;
        case (kind)
            REQ_ALLOC: begin
                if (free_top == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    free_top = free_top - 1'b1;
                    r.addr = stack_mirror[free_top];
                    if (used_blocks != BLOCKS_SAT) begin
                        used_blocks = used_blocks + 1'b1;
                    end
                    refresh_bytes();
                end
            end
            REQ_FREE: begin
                if (addr_in == '0) begin
                    r.status = STAT_NULL_FREE;
                end else if (free_top >= 9'(POOL_DEPTH)) begin
                    r.status = STAT_FULL;
                end else begin
                    stack_mirror[free_top] = addr_in;
                    free_top = free_top + 1'b1;
                    if (used_blocks != '0) begin
                        used_blocks = used_blocks - 1'b1;
                    end
                    refresh_bytes();
                end
            end
            REQ_REBUILD: begin
                n = (cfg_count > BCOUNT_W'(POOL_DEPTH)) ? BCOUNT_W'(POOL_DEPTH) : cfg_count;
                blk_size = rounded_size(cfg_bytes);
                for (i = 0; i < int'(n); i++) begin
                    stack_mirror[i] = cfg_base + ADDR_W'(i) * ADDR_W'(blk_size);
                end
                free_top    = 9'(n);
                used_blocks = '0;
                used_bytes  = '0;
            end
            default: ;
        endcase
        r.used  = used_blocks;
        r.bytes = used_bytes;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        pool_reply_t want;
        pool_reply_t got;
        if (!aresetn) begin
            free_top    = '0;
            used_blocks = '0;
            used_bytes  = '0;
            blk_size    = ELEM_RESET;
            cfg_base    = '0;
            cfg_bytes   = BSIZE_RESET;
            cfg_count   = BCOUNT_RESET;
            replies_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_POOL_BASE:   cfg_base  = cfg_wr_data[ADDR_W-1:0];
                    CFG_BLOCK_BYTES: cfg_bytes = cfg_wr_data[BSIZE_W-1:0];
                    CFG_BLOCK_COUNT: cfg_count = cfg_wr_data[BCOUNT_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.addr   = m_tdata[ADDR_W-1:0];
                got.status = m_tdata[ADDR_W +: STATUS_W];
                got.used   = m_tdata[ADDR_W+STATUS_W +: USED_W];
                got.bytes  = m_tdata[ADDR_W+STATUS_W+USED_W +: BYTES_W];
                if (replies_due.size() == 0) begin
                    errors++;
                    $error("result with no request outstanding: %h", m_tdata);
                end else begin
                    want = replies_due.pop_front();
                    checked++;
                    // keep the log readable when the block is badly broken
                    if (got.addr !== want.addr) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $error("block_address: expected %h, got %h", want.addr, got.addr);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $error("status: expected %0d, got %0d", want.status, got.status);
                    end
                    if (got.used !== want.used) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $error("blocks_in_use: expected %0d, got %0d", want.used, got.used);
                    end
                    if (got.bytes !== want.bytes) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $error("bytes_in_use: expected %0d, got %0d", want.bytes, got.bytes);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                replies_due.push_back(pool_step(s_tuser, s_tdata[ADDR_W-1:0]));
            end
        end
        pending <= replies_due.size();
    end

endmodule

>>> test/fixed_block_pool_allocator_core_tb.sv
`timescale 1ns / 100ps
module fixed_block_pool_allocator_core_tb;
    import fbpa_pkg::*;

    localparam int REQ_TARGET   = 1850;
    localparam int QUIET_FROM   = 1700;
    localparam int STALL_AT     = 400;
    localparam int STALL_CYCLES = 300;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_ROOM   = 600;

    // selector value the block passes through untouched
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic [REQ_W-1:0]       s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    int errors;
    int pending;
    int checked;

    int idle_pct;
    bit quiet;
    bit stall_done;
    int stuck_cycles;
    int sent_total, n_alloc, n_free, n_rebuild, n_ignored, n_settings;

    logic [ADDR_W-1:0]   cur_base  = '0;
    logic [BSIZE_W-1:0]  cur_bytes = BSIZE_RESET;
    logic [BCOUNT_W-1:0] cur_count = BCOUNT_RESET;

    always #5 aclk = ~aclk;

    fixed_block_pool_allocator_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    fbpa_scoreboard u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [IN_TDATA_W-1:0] data);
        if (sent_total >= QUIET_FROM) begin
            quiet    = 1'b1;
            idle_pct = 0;
        end
        if ($urandom_range(1, 100) <= idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sent_total++;
        case (kind)
            REQ_ALLOC:   n_alloc++;
            REQ_FREE:    n_free++;
            REQ_REBUILD: n_rebuild++;
            default:     n_ignored++;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [BSIZE_W-1:0] bytes,
                            input logic [BCOUNT_W-1:0] count);
        wait_drained();
        cur_base  = base;
        cur_bytes = bytes;
        cur_count = count;
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_POOL_BASE;
        cfg_wr_data <= base;
        @(posedge aclk);
        cfg_addr    <= CFG_BLOCK_BYTES;
        cfg_wr_data <= CFG_DATA_W'(bytes);
        @(posedge aclk);
        cfg_addr    <= CFG_BLOCK_COUNT;
        cfg_wr_data <= CFG_DATA_W'(count);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        n_settings++;
    endtask

    // some block of the current pool, so most frees look like real returns
    function automatic logic [ADDR_W-1:0] pool_addr();
        logic [ADDR_W-1:0] blk;
        blk = (cur_bytes < 8) ? ADDR_W'(8) : ((ADDR_W'(cur_bytes) + 7) & ~ADDR_W'(7));
        return cur_base + blk * $urandom_range(0, (cur_count > 1) ? cur_count - 1 : 0);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] free_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 18) return $urandom();
        return pool_addr();
    endfunction

    task automatic run_ops(input int n_ops, input int alloc_pct);
        int r;
        repeat (n_ops) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                send_req(REQ_REBUILD, $urandom());
            else if (r < 6)
                send_req(REQ_IGNORED, $urandom());
            else if (r < 6 + alloc_pct)
                send_req(REQ_ALLOC, $urandom());
            else
                send_req(REQ_FREE, free_data());
        end
    endtask

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (aresetn && !stall_done && sent_total >= STALL_AT) begin
                // long hold-off so the block backs up into its input
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (aresetn && $urandom_range(1, 100) <= idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        int p;
        logic [ADDR_W-1:0]   base;
        logic [BSIZE_W-1:0]  bytes;
        logic [BCOUNT_W-1:0] count;

        idle_pct = 20;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // list is empty out of reset
        send_req(REQ_ALLOC, '0);
        send_req(REQ_FREE, '0);
        send_req(REQ_FREE, 32'hFFFF_FFFF);   // push while nothing is in use
        send_req(REQ_FREE, 32'h8000_0000);
        send_req(REQ_IGNORED, 32'hFFFF_FFFF);
        send_req(REQ_ALLOC, 32'hFFFF_FFFF);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_REBUILD, '0);           // default settings fill all 256 slots
        send_req(REQ_FREE, 32'h0000_0008);   // list full
        send_req(REQ_ALLOC, '0);
        send_req(REQ_IGNORED, '0);

        // zero size, count past the pool depth, addresses wrapping
        set_pool(32'hFFFF_FFF0, 13'd0, 9'd511);
        send_req(REQ_REBUILD, '0);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_FREE, 32'h5555_5555);

        // empty rebuild with the largest size
        set_pool(32'h0000_1000, 13'd8191, 9'd0);
        send_req(REQ_REBUILD, '0);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_FREE, 32'hAAAA_AAAA);
        send_req(REQ_ALLOC, '0);

        set_pool(32'h1234_5678, 13'd1, 9'd1);
        send_req(REQ_REBUILD, '0);
        send_req(REQ_ALLOC, '0);
        send_req(REQ_ALLOC, '0);

        p = 0;
        while (sent_total < REQ_TARGET) begin
            case ($urandom_range(0, 7))
                0:       base = '0;
                1:       base = 32'hFFFF_FFFF - $urandom_range(0, 8191);
                default: base = $urandom();
            endcase
            case ($urandom_range(0, 7))
                0:       bytes = '0;
                1:       bytes = 13'd4096;
                2:       bytes = '1;
                3:       bytes = $urandom_range(0, 8191);
                default: bytes = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 7))
                0:       count = '0;
                1:       count = 9'd256;
                2:       count = '1;
                3:       count = $urandom_range(0, 511);
                default: count = $urandom_range(1, 24);
            endcase

            // the long drain pass only while there is room left in the request budget
            if (p % 6 == 2 && sent_total < REQ_TARGET - DRAIN_ROOM) begin
                // drain the whole pool, then push it back until it overflows
                set_pool(base, (p % 12 == 2) ? 13'd8191 : bytes, 9'd256);
                if (!quiet)
                    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
                send_req(REQ_REBUILD, $urandom());
                repeat (260) send_req(REQ_ALLOC, $urandom());
                run_ops(280, 4);
            end else begin
                set_pool(base, bytes, count);
                if (!quiet)
                    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
                send_req(REQ_REBUILD, $urandom());
                run_ops($urandom_range(15, 60), $urandom_range(30, 60));
            end
            p++;
        end

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("covered %0d requests: %0d alloc, %0d free, %0d rebuild, %0d ignored",
                 sent_total, n_alloc, n_free, n_rebuild, n_ignored);
        $display("%0d pool settings, %0d results checked, %0d mismatches",
                 n_settings, checked, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> fixed_block_pool_allocator_core.f
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fixed_block_pool_allocator_core.sv
rtl/fbpa_checker.sv
test/fbpa_checker.sv
test/fixed_block_pool_allocator_core_tb.sv
